>>> sv/fat12ct_pkg.sv
package fat12ct_pkg;

  localparam int ENTRY_COUNT = 4096;
  localparam int ENTRY_W = $clog2(ENTRY_COUNT);
  localparam int DATA_W = 12;
  localparam logic [DATA_W-1:0] LAST_ENTRY = DATA_W'(ENTRY_COUNT - 1);
  localparam logic [DATA_W-1:0] END_MARK = 12'hfff;
  localparam logic [ENTRY_W-1:0] FIRST_CLUSTER = ENTRY_W'(2);

  localparam logic [1:0] MODE_READ = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_ALLOC = 2'd2;

  typedef struct packed {
    logic                en;
    logic [ENTRY_W-1:0]  addr;
    logic [DATA_W-1:0]   data;
  } tbl_wr_t;

endpackage

>>> sv/fat12_cluster_table_engine.sv
// read: done comes from ST_READ; write and unused mode: done in the cycle after start
// allocate: ST_SCAN finds a free cluster from cluster 2 on, ST_MARK marks it, ST_LINK links it
// one table entry checked per cycle; an item may start the cycle done shows
// a full table answers full once the scan reaches the limit; a limit below 2 answers from ST_IDLE
// reset runs a clearing pass over all 4096 entries with busy high; config writes are taken then
// results come as a one-cycle done strobe and cannot be held off
module fat12_cluster_table_engine import fat12ct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode,
  input  logic [DATA_W-1:0] cluster,
  input  logic [DATA_W-1:0] entry_value,
  output logic              done,
  output logic [DATA_W-1:0] result_value,
  output logic              status,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DATA_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_MARK  = 6'b010000,
    ST_LINK  = 6'b100000
  } state_t;

  state_t             state;
  logic [ENTRY_W-1:0] clr_addr;
  logic [DATA_W-1:0]  cluster_limit;
  logic [DATA_W-1:0]  cluster_q;
  logic               in_range_q;
  logic [ENTRY_W:0]   scan_addr;
  logic [ENTRY_W-1:0] chk_addr;
  logic               chk_valid;
  logic [ENTRY_W-1:0] found;

  tbl_wr_t            wr;
  logic [ENTRY_W-1:0] raddr;
  logic [DATA_W-1:0]  rdata;

  logic               in_range;
  logic [ENTRY_W-1:0] limit_eff;
  logic               issue;

  assign busy = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_range = (cluster <= LAST_ENTRY);
  assign limit_eff = (cluster_limit > LAST_ENTRY) ? LAST_ENTRY[ENTRY_W-1:0]
                                                  : cluster_limit[ENTRY_W-1:0];
  assign issue = (scan_addr <= {1'b0, limit_eff});

  always_comb begin
    wr = '0;
    raddr = scan_addr[ENTRY_W-1:0];
    unique case (state)
      ST_CLEAR: begin
        wr.en = 1'b1;
        wr.addr = clr_addr;
        wr.data = '0;
      end
      ST_IDLE: begin
        raddr = cluster[ENTRY_W-1:0];
        wr.en = start && (mode == MODE_WRITE) && in_range;
        wr.addr = cluster[ENTRY_W-1:0];
        wr.data = entry_value;
      end
      ST_MARK: begin
        wr.en = 1'b1;
        wr.addr = found;
        wr.data = END_MARK;
      end
      ST_LINK: begin
        wr.en = 1'b1;
        wr.addr = cluster_q[ENTRY_W-1:0];
        wr.data = DATA_W'(found);
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  fat12ct_table u_table (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_addr <= '0;
      done <= 1'b0;
      cluster_limit <= 12'hfff;
      chk_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid) begin
        cluster_limit <= cfg_data;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == LAST_ENTRY[ENTRY_W-1:0]) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cluster_q <= cluster;
            in_range_q <= in_range;
            result_value <= '0;
            status <= 1'b0;
            unique case (mode)
              MODE_READ: begin
                state <= ST_READ;
              end
              MODE_ALLOC: begin
                if (limit_eff < FIRST_CLUSTER) begin
                  done <= 1'b1;
                  status <= 1'b1;
                end else begin
                  state <= ST_SCAN;
                  scan_addr <= {1'b0, FIRST_CLUSTER};
                  chk_valid <= 1'b0;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_READ: begin
          done <= 1'b1;
          result_value <= in_range_q ? rdata : '0;
          status <= 1'b0;
          state <= ST_IDLE;
        end
        ST_SCAN: begin
          if (chk_valid && (rdata == '0)) begin
            found <= chk_addr;
            state <= ST_MARK;
          end else if (chk_valid && (chk_addr == limit_eff)) begin
            done <= 1'b1;
            result_value <= '0;
            status <= 1'b1;
            state <= ST_IDLE;
          end else begin
            chk_valid <= issue;
            if (issue) begin
              chk_addr <= scan_addr[ENTRY_W-1:0];
              scan_addr <= scan_addr + 1'b1;
            end
          end
        end
        ST_MARK: begin
          if ((cluster_q != '0) && in_range_q) begin
            state <= ST_LINK;
          end else begin
            done <= 1'b1;
            result_value <= DATA_W'(found);
            status <= 1'b0;
            state <= ST_IDLE;
          end
        end
        ST_LINK: begin
          done <= 1'b1;
          result_value <= DATA_W'(found);
          status <= 1'b0;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_no_done_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !done)
    else $error("result during clearing pass");

  a_full_reads_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (result_value == '0))
    else $error("full status with nonzero value");

  a_read_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_READ)) |=> (busy && !done))
    else $error("read item not held busy");

  a_alloc_not_reserved: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_LINK) || (state == ST_MARK)) |-> (found >= FIRST_CLUSTER))
    else $error("allocated a reserved cluster");

endmodule

>>> sv/fat12ct_table.sv
module fat12ct_table import fat12ct_pkg::*; (
  input  logic               clk,
  input  tbl_wr_t            wr,
  input  logic [ENTRY_W-1:0] raddr,
  output logic [DATA_W-1:0]  rdata
);

  logic [DATA_W-1:0] mem [ENTRY_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> test/tb_fat12_cluster_table_engine.sv
module tb_fat12_cluster_table_engine import fat12ct_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FULL = 1'b1;
  localparam logic [DATA_W-1:0] LIMIT_RESET = 12'd4095;
  localparam int TABLE_BYTES = (3 * ENTRY_COUNT + 1) / 2;
  localparam int PHASE_ITEMS = 200;
  localparam int PHASE_COUNT = 6;
  localparam longint CYCLE_LIMIT = 64'd24_000_000;
  localparam int DIR_COUNT = 31;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        mode;
  logic [DATA_W-1:0] cluster;
  logic [DATA_W-1:0] entry_value;
  logic              done;
  logic [DATA_W-1:0] result_value;
  logic              status;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [DATA_W-1:0] cfg_data;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              st;
  } fat_answer_t;

  typedef struct packed {
    logic              cfg;
    logic [1:0]        m;
    logic [DATA_W-1:0] c;
    logic [DATA_W-1:0] v;
    logic              fixed;
    logic [DATA_W-1:0] res;
    logic              st;
  } dir_row_t;

  // cfg rows carry the new cluster limit in v
  dir_row_t dir_rows [DIR_COUNT] = '{
    '{1'b0, MODE_READ,   12'd0,    12'h000, 1'b1, 12'h000, STATUS_OK},
    '{1'b0, MODE_READ,   12'd4095, 12'h000, 1'b1, 12'h000, STATUS_OK},
    '{1'b0, MODE_WRITE,  12'd3,    12'habc, 1'b1, 12'h000, STATUS_OK},
    '{1'b0, MODE_READ,   12'd3,    12'h000, 1'b1, 12'habc, STATUS_OK},
    '{1'b0, MODE_READ,   12'd2,    12'h000, 1'b1, 12'h000, STATUS_OK},
    '{1'b0, MODE_WRITE,  12'd2,    12'hfff, 1'b1, 12'h000, STATUS_OK},
    '{1'b0, MODE_WRITE,  12'd4095, 12'h5a5, 1'b1, 12'h000, STATUS_OK},
    '{1'b0, MODE_READ,   12'd4095, 12'h000, 1'b1, 12'h5a5, STATUS_OK},
    '{1'b0, MODE_READ,   12'd4094, 12'h000, 1'b1, 12'h000, STATUS_OK},
    '{1'b0, MODE_UNUSED, 12'd7,    12'h07b, 1'b1, 12'h000, STATUS_OK},
    '{1'b0, MODE_ALLOC,  12'd0,    12'h000, 1'b1, 12'd4,   STATUS_OK},
    '{1'b0, MODE_READ,   12'd4,    12'h000, 1'b1, 12'hfff, STATUS_OK},
    '{1'b0, MODE_ALLOC,  12'd4,    12'h000, 1'b1, 12'd5,   STATUS_OK},
    '{1'b0, MODE_READ,   12'd4,    12'h000, 1'b1, 12'd5,   STATUS_OK},
    '{1'b0, MODE_ALLOC,  12'd1,    12'h000, 1'b1, 12'd6,   STATUS_OK},
    '{1'b0, MODE_READ,   12'd1,    12'h000, 1'b1, 12'd6,   STATUS_OK},
    '{1'b0, MODE_ALLOC,  12'd7,    12'h000, 1'b1, 12'd7,   STATUS_OK},
    '{1'b0, MODE_READ,   12'd7,    12'h000, 1'b1, 12'd7,   STATUS_OK},
    '{1'b1, MODE_READ,   12'd0,    12'd2,   1'b0, 12'h000, STATUS_OK},
    '{1'b0, MODE_ALLOC,  12'd0,    12'h000, 1'b1, 12'h000, STATUS_FULL},
    '{1'b1, MODE_READ,   12'd0,    12'd1,   1'b0, 12'h000, STATUS_OK},
    '{1'b0, MODE_ALLOC,  12'd5,    12'h000, 1'b1, 12'h000, STATUS_FULL},
    '{1'b0, MODE_READ,   12'd5,    12'h000, 1'b1, 12'hfff, STATUS_OK},
    '{1'b1, MODE_READ,   12'd0,    12'd0,   1'b0, 12'h000, STATUS_OK},
    '{1'b0, MODE_ALLOC,  12'd0,    12'h000, 1'b1, 12'h000, STATUS_FULL},
    '{1'b1, MODE_READ,   12'd0,    12'd4095, 1'b0, 12'h000, STATUS_OK},
    '{1'b0, MODE_ALLOC,  12'd0,    12'h000, 1'b1, 12'd8,   STATUS_OK},
    '{1'b0, MODE_WRITE,  12'd0,    12'hfff, 1'b1, 12'h000, STATUS_OK},
    '{1'b0, MODE_WRITE,  12'd1,    12'h0f0, 1'b1, 12'h000, STATUS_OK},
    '{1'b0, MODE_READ,   12'd0,    12'h000, 1'b0, 12'h000, STATUS_OK},
    '{1'b0, MODE_READ,   12'd1,    12'h000, 1'b0, 12'h000, STATUS_OK}
  };

  logic [7:0]        fat_bytes [TABLE_BYTES];
  logic [DATA_W-1:0] limit_shadow;
  fat_answer_t       pending_answers [$];
  int                err_count;
  longint            cycle_count;

  logic              fix_en;
  logic [DATA_W-1:0] fix_value;
  logic              fix_status;

  fat12_cluster_table_engine i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .cluster      (cluster),
    .entry_value  (entry_value),
    .done         (done),
    .result_value (result_value),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] fat_get(logic [DATA_W-1:0] c);
    int off;
    off = int'(c) + int'(c >> 1);
    if (int'(c) >= ENTRY_COUNT || off + 1 >= TABLE_BYTES) return '0;
    if (c[0]) return {fat_bytes[off+1], fat_bytes[off][7:4]};
    return {fat_bytes[off+1][3:0], fat_bytes[off]};
  endfunction

  function automatic void fat_put(logic [DATA_W-1:0] c, logic [DATA_W-1:0] v);
    int off;
    off = int'(c) + int'(c >> 1);
    if (int'(c) >= ENTRY_COUNT || off + 1 >= TABLE_BYTES) return;
    if (c[0]) begin
      fat_bytes[off] = {v[3:0], fat_bytes[off][3:0]};
      fat_bytes[off+1] = v[11:4];
    end else begin
      fat_bytes[off] = v[7:0];
      fat_bytes[off+1] = {fat_bytes[off+1][7:4], v[11:8]};
    end
  endfunction

  function automatic fat_answer_t fat_apply(logic [1:0] m, logic [DATA_W-1:0] c,
                                            logic [DATA_W-1:0] v);
    fat_answer_t r;
    int top;
    int k;
    int hit;
    r = '0;
    case (m)
      MODE_READ: r.value = fat_get(c);
      MODE_WRITE: fat_put(c, v);
      MODE_ALLOC: begin
        top = (limit_shadow > LAST_ENTRY) ? int'(LAST_ENTRY) : int'(limit_shadow);
        hit = 0;
        for (k = int'(FIRST_CLUSTER); k <= top && hit == 0; k++) begin
          if (fat_get(DATA_W'(k)) == '0) hit = k;
        end
        if (hit == 0) begin
          r.st = STATUS_FULL;
        end else begin
          fat_put(DATA_W'(hit), END_MARK);
          if (c != '0) fat_put(c, DATA_W'(hit));
          r.value = DATA_W'(hit);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_error(string msg);
    err_count++;
    if (err_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : monitor
    fat_answer_t want;
    fat_answer_t got;
    if (rst) begin
      foreach (fat_bytes[i]) fat_bytes[i] = 8'h00;
      limit_shadow = LIMIT_RESET;
      pending_answers.delete();
    end else begin
      if (done) begin
        if (pending_answers.size() == 0) begin
          note_error($sformatf("unexpected result: value %h status %0d",
                               result_value, status));
        end else begin
          want = pending_answers.pop_front();
          if (result_value !== want.value || status !== want.st)
            note_error($sformatf("mismatch: expected value %h status %0d, got value %h status %0d",
                                 want.value, want.st, result_value, status));
        end
      end
      if (start && !busy) begin
        got = fat_apply(mode, cluster, entry_value);
        if (fix_en) got = '{value: fix_value, st: fix_status};
        pending_answers.push_back(got);
      end
      if (cfg_valid && cfg_ready) limit_shadow = cfg_data;
    end
    cycle_count <= cycle_count + 1;
  end

  task automatic send_item(logic [1:0] m, logic [DATA_W-1:0] c, logic [DATA_W-1:0] v,
                           logic fx, logic [DATA_W-1:0] fres, logic fst);
    @(negedge clk);
    start = 1'b1;
    mode = m;
    cluster = c;
    entry_value = v;
    fix_en = fx;
    fix_value = fres;
    fix_status = fst;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle(int n);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    idle(1);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_item(int window);
    logic [1:0]        m;
    logic [DATA_W-1:0] c;
    logic [DATA_W-1:0] v;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) m = MODE_READ;
    else if (pick < 65) m = MODE_WRITE;
    else if (pick < 95) m = MODE_ALLOC;
    else m = MODE_UNUSED;
    if ($urandom_range(0, 9) < 7) c = DATA_W'($urandom_range(0, window));
    else c = DATA_W'($urandom);
    if (m == MODE_ALLOC && $urandom_range(0, 2) == 0) c = '0;
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = END_MARK;
      default: v = DATA_W'($urandom);
    endcase
    send_item(m, c, v, 1'b0, '0, STATUS_OK);
  endtask

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [DATA_W-1:0] limits [PHASE_COUNT];
    int window;
    int sent;
    int burst;
    int gap;
    int j;
    cycle_count = 0;
    err_count = 0;
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_READ;
    cluster = '0;
    entry_value = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    fix_en = 1'b0;
    fix_value = '0;
    fix_status = STATUS_OK;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].cfg) begin
        drain();
        write_limit(dir_rows[i].v);
      end else begin
        send_item(dir_rows[i].m, dir_rows[i].c, dir_rows[i].v,
                  dir_rows[i].fixed, dir_rows[i].res, dir_rows[i].st);
      end
    end

    limits[0] = LIMIT_RESET;
    limits[1] = 12'd17;
    limits[2] = 12'd2;
    limits[3] = DATA_W'($urandom_range(2, 4095));
    limits[4] = 12'd40;
    limits[5] = LIMIT_RESET;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain();
      write_limit(limits[p]);
      window = (limits[p] < 200) ? int'(limits[p]) + 8 : 64;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 24);
        for (j = 0; j < burst && sent < PHASE_ITEMS; j++) begin
          random_item(window);
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) idle(gap);
        if ($urandom_range(0, 15) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (pending_answers.size() != 0)
      note_error($sformatf("%0d results never arrived", pending_answers.size()));
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
